FILE: hw/rtl/wsunmask_pkg.sv
package wsunmask_pkg;

	// Default number of payload length bits kept by the parser.
	localparam int unsigned LENGTH_BITS_DEF = 64;

	// Width of the frame_length field on the result beat.
	localparam int unsigned FRAME_LEN_W = 64;

	// Result tdata: payload_byte, frame_opcode, frame_fin, frame_length, padded to bytes.
	localparam int unsigned RES_FIELDS_W = 8 + 4 + 1 + FRAME_LEN_W;
	localparam int unsigned RES_TDATA_W  = ((RES_FIELDS_W + 7) / 8) * 8;

	// Length codes in the second header byte that select an extended length.
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Number of extended length bytes for each extended code.
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             payload_byte;
		logic                   last_byte;
		logic [3:0]             frame_opcode;
		logic                   frame_fin;
		logic [FRAME_LEN_W-1:0] frame_length;
	} res_t;

endpackage

FILE: hw/rtl/websocket_frame_unmask_parser.sv
// A result beat is registered in the output register, or in the skid entry while m_axis stalls.
// Throughput: one input byte per cycle while the skid entry is empty; a two-entry output
// buffer keeps input flowing while a result waits.
// Header, length and key bytes give no result unless the frame is unmasked or empty.
// Reset (arst_n low) returns the parser to waiting for a first header byte and empties
// the output buffer; the masking key is not cleared, since every frame rewrites it.
module websocket_frame_unmask_parser #(
	parameter int unsigned LENGTH_BITS = wsunmask_pkg::LENGTH_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata, // [7:0] stream_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] payload_byte, [11:8] frame_opcode, [12] frame_fin, [76:13] frame_length,
	// upper bits zero
	output logic [wsunmask_pkg::RES_TDATA_W-1:0] m_axis_tdata,
	output logic                                m_axis_tlast,  // last_byte
	output logic [1:0]                          m_axis_tuser   // [1:0] kind
);

	localparam int unsigned LB = LENGTH_BITS;

	wsunmask_pkg::phase_t phase_q;
	logic [7:0]           hdr_q;
	logic [3:0]           ext_left_q;
	logic [LB-1:0]        plen_q;
	logic [LB-1:0]        rem_q;
	logic [7:0]           key_q [4];
	logic [1:0]           key_idx_q;

	logic                 in_acc;
	logic [7:0]           b;
	logic [1:0]           key_idx_inc;
	logic [LB-1:0]        rem_dec;
	logic [3:0]           ext_left_dec;
	logic                 res_valid;
	wsunmask_pkg::res_t   res;

	logic                 out_valid_q;
	wsunmask_pkg::res_t   out_q;
	logic                 skid_valid_q;
	wsunmask_pkg::res_t   skid_q;

	assign s_axis_tready = !skid_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign key_idx_inc   = key_idx_q + 2'd1;
	assign rem_dec       = rem_q - LB'(1);
	assign ext_left_dec  = ext_left_q - 4'd1;

	// Result of the current byte, valid only on an accepted beat.
	always_comb begin
		res_valid          = 1'b0;
		res.kind           = wsunmask_pkg::KIND_PAYLOAD;
		res.payload_byte   = 8'd0;
		res.last_byte      = 1'b0;
		res.frame_opcode   = hdr_q[3:0];
		res.frame_fin      = hdr_q[7];
		res.frame_length   = '0;
		case (phase_q)
			wsunmask_pkg::PH_HDR1: begin
				if (!b[7]) begin
					res_valid     = in_acc;
					res.kind      = wsunmask_pkg::KIND_REJECT;
					res.last_byte = 1'b1;
				end
			end
			wsunmask_pkg::PH_KEY: begin
				if (key_idx_inc == 2'd0 && plen_q == '0) begin
					res_valid     = in_acc;
					res.kind      = wsunmask_pkg::KIND_EMPTY;
					res.last_byte = 1'b1;
				end
			end
			wsunmask_pkg::PH_DATA: begin
				res_valid        = in_acc;
				res.payload_byte = b ^ key_q[key_idx_q];
				res.last_byte    = (rem_dec == '0);
				res.frame_length = wsunmask_pkg::FRAME_LEN_W'(plen_q);
			end
			default: ;
		endcase
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsunmask_pkg::PH_HDR0;
			hdr_q      <= 8'd0;
			ext_left_q <= 4'd0;
			plen_q     <= '0;
			rem_q      <= '0;
			key_idx_q  <= 2'd0;
		end else if (in_acc) begin
			case (phase_q)
				wsunmask_pkg::PH_HDR0: begin
					hdr_q   <= b;
					phase_q <= wsunmask_pkg::PH_HDR1;
				end
				wsunmask_pkg::PH_HDR1: begin
					if (!b[7]) begin
						phase_q <= wsunmask_pkg::PH_HDR0;
					end else begin
						key_idx_q <= 2'd0;
						if (b[6:0] == wsunmask_pkg::LEN_CODE_EXT16) begin
							plen_q     <= '0;
							ext_left_q <= wsunmask_pkg::EXT16_BYTES;
							phase_q    <= wsunmask_pkg::PH_EXT;
						end else if (b[6:0] == wsunmask_pkg::LEN_CODE_EXT64) begin
							plen_q     <= '0;
							ext_left_q <= wsunmask_pkg::EXT64_BYTES;
							phase_q    <= wsunmask_pkg::PH_EXT;
						end else begin
							plen_q  <= LB'(b[6:0]);
							phase_q <= wsunmask_pkg::PH_KEY;
						end
					end
				end
				wsunmask_pkg::PH_EXT: begin
					// Big-endian: older bytes shift up, overflowing bytes fall off the top.
					plen_q     <= {plen_q[LB-9:0], b};
					ext_left_q <= ext_left_dec;
					if (ext_left_dec == 4'd0) begin
						key_idx_q <= 2'd0;
						phase_q   <= wsunmask_pkg::PH_KEY;
					end
				end
				wsunmask_pkg::PH_KEY: begin
					key_idx_q <= key_idx_inc;
					if (key_idx_inc == 2'd0) begin
						if (plen_q == '0) begin
							phase_q <= wsunmask_pkg::PH_HDR0;
						end else begin
							rem_q   <= plen_q;
							phase_q <= wsunmask_pkg::PH_DATA;
						end
					end
				end
				wsunmask_pkg::PH_DATA: begin
					key_idx_q <= key_idx_inc;
					rem_q     <= rem_dec;
					if (rem_dec == '0) begin
						phase_q <= wsunmask_pkg::PH_HDR0;
					end
				end
				default: begin
					phase_q <= wsunmask_pkg::PH_HDR0;
				end
			endcase
		end
	end

	// Masking key bytes, written in order during the key phase.
	always_ff @(posedge clk) begin
		if (in_acc && phase_q == wsunmask_pkg::PH_KEY) begin
			key_q[key_idx_q] <= b;
		end
	end

	// Output buffer: a result goes to the output register, or to the skid entry when
	// the output register is full and not being taken this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_axis_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.last_byte;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = wsunmask_pkg::RES_TDATA_W'({out_q.frame_length, out_q.frame_fin,
		out_q.frame_opcode, out_q.payload_byte});

endmodule
